@@ design/vcflf_pkg.sv @@
// Shared constants, types and helper functions of the VCF common-variant line filter.
`default_nettype none
package vcflf_pkg;

	localparam int COUNT_BITS  = 24;
	localparam int BP_BITS     = 13;
	localparam int SCALE_BITS  = 14;
	localparam int PROD_BITS   = COUNT_BITS + SCALE_BITS;
	localparam int BP_SCALE    = 10000;
	localparam int BP_RESET    = 100;

	// The line record queue depth must be a power of two.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_EQ   = 8'h3D;
	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_C    = 8'h43;
	localparam logic [7:0] CH_N    = 8'h4E;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;

	localparam logic [2:0] INFO_TABS     = 3'd7;
	localparam logic [2:0] PRE_INFO_TABS = 3'd6;

	localparam logic [2:0] KM_IDLE = 3'd0;
	localparam logic [2:0] KM_SEMI = 3'd1;
	localparam logic [2:0] KM_A    = 3'd2;
	localparam logic [2:0] KM_AC   = 3'd3;
	localparam logic [2:0] KM_AN   = 3'd4;

	localparam logic [1:0] NT_NONE = 2'd0;
	localparam logic [1:0] NT_AC   = 2'd1;
	localparam logic [1:0] NT_AN   = 2'd2;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_NO_INFO    = 3'd1;
	localparam logic [2:0] ERR_AC_MISSING = 3'd2;
	localparam logic [2:0] ERR_AN_MISSING = 3'd3;
	localparam logic [2:0] ERR_OVERFLOW   = 3'd4;

	typedef logic [COUNT_BITS-1:0] count_t;

	typedef struct packed {
		logic       is_header;
		logic [2:0] err;
		count_t     ac;
		count_t     an;
	} line_rec_t;

	typedef struct packed {
		count_t value;
		logic   ovf;
	} acc_t;

	function automatic acc_t acc_digit(count_t v, logic [3:0] d);
		logic [COUNT_BITS+3:0] n;
		acc_t r;
		n = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {{COUNT_BITS{1'b0}}, d};
		r.ovf = |n[COUNT_BITS+3:COUNT_BITS];
		r.value = r.ovf ? {COUNT_BITS{1'b1}} : n[COUNT_BITS-1:0];
		return r;
	endfunction

endpackage
`default_nettype wire

@@ design/vcflf_front.sv @@
// Byte parser that tracks fields and keys of a line and classifies it at the newline.
`default_nettype none
module vcflf_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            data_byte,
	input  logic                  accept,
	output logic                  push,
	output vcflf_pkg::line_rec_t  push_rec
);
	import vcflf_pkg::*;

	logic       line_start_q, line_start_d;
	logic       header_q, header_d;
	logic       info_done_q, info_done_d;
	logic       ac_seen_q, ac_seen_d;
	logic       an_seen_q, an_seen_d;
	logic [2:0] tab_q, tab_d;
	logic [2:0] kmp_q, kmp_d;
	logic [1:0] nt_q, nt_d;
	count_t     ac_q, ac_d;
	count_t     an_q, an_d;
	logic       ac_found_q, ac_found_d;
	logic       an_found_q, an_found_d;
	logic       ovf_q, ovf_d;

	logic       is_lf;
	logic       is_digit;
	acc_t       acc;

	assign is_lf    = (data_byte == CH_LF);
	assign is_digit = (data_byte >= CH_0) && (data_byte <= CH_9);
	assign acc      = acc_digit((nt_q == NT_AN) ? an_q : ac_q, data_byte[3:0]);

	always_comb begin
		line_start_d = line_start_q;
		header_d     = header_q;
		info_done_d  = info_done_q;
		ac_seen_d    = ac_seen_q;
		an_seen_d    = an_seen_q;
		tab_d        = tab_q;
		kmp_d        = kmp_q;
		nt_d         = nt_q;
		ac_d         = ac_q;
		an_d         = an_q;
		ac_found_d   = ac_found_q;
		an_found_d   = an_found_q;
		ovf_d        = ovf_q;
		if (accept) begin
			if (is_lf) begin
				line_start_d = 1'b1;
				header_d     = 1'b0;
				info_done_d  = 1'b0;
				ac_seen_d    = 1'b0;
				an_seen_d    = 1'b0;
				tab_d        = '0;
				kmp_d        = KM_IDLE;
				nt_d         = NT_NONE;
				ac_d         = '0;
				an_d         = '0;
				ac_found_d   = 1'b0;
				an_found_d   = 1'b0;
				ovf_d        = 1'b0;
			end else begin
				line_start_d = 1'b0;
				if (line_start_q && (data_byte == CH_HASH)) begin
					header_d = 1'b1;
				end else if (!header_q && !info_done_q) begin
					if (data_byte == CH_TAB) begin
						if (tab_q != INFO_TABS) begin
							tab_d = tab_q + 3'd1;
							if (tab_q == PRE_INFO_TABS) begin
								kmp_d = KM_SEMI;
							end
						end else begin
							info_done_d = 1'b1;
							nt_d        = NT_NONE;
							kmp_d       = KM_IDLE;
						end
					end else if (tab_q == INFO_TABS) begin
						if ((nt_q != NT_NONE) && is_digit) begin
							if (nt_q == NT_AC) begin
								ac_d       = acc.value;
								ac_found_d = 1'b1;
							end else begin
								an_d       = acc.value;
								an_found_d = 1'b1;
							end
							if (acc.ovf) begin
								ovf_d = 1'b1;
							end
						end else begin
							nt_d = NT_NONE;
							if (data_byte == CH_SEMI) begin
								kmp_d = KM_SEMI;
							end else begin
								unique case (kmp_q)
									KM_SEMI: begin
										kmp_d = (data_byte == CH_A) ? KM_A : KM_IDLE;
									end
									KM_A: begin
										if (data_byte == CH_C) begin
											kmp_d = KM_AC;
										end else if (data_byte == CH_N) begin
											kmp_d = KM_AN;
										end else begin
											kmp_d = KM_IDLE;
										end
									end
									KM_AC: begin
										if ((data_byte == CH_EQ) && !ac_seen_q) begin
											ac_seen_d = 1'b1;
											nt_d      = NT_AC;
										end
										kmp_d = KM_IDLE;
									end
									KM_AN: begin
										if ((data_byte == CH_EQ) && !an_seen_q) begin
											an_seen_d = 1'b1;
											nt_d      = NT_AN;
										end
										kmp_d = KM_IDLE;
									end
									default: begin
										kmp_d = KM_IDLE;
									end
								endcase
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_start_q <= 1'b1;
			header_q     <= 1'b0;
			info_done_q  <= 1'b0;
			ac_seen_q    <= 1'b0;
			an_seen_q    <= 1'b0;
			tab_q        <= '0;
			kmp_q        <= KM_IDLE;
			nt_q         <= NT_NONE;
			ac_q         <= '0;
			an_q         <= '0;
			ac_found_q   <= 1'b0;
			an_found_q   <= 1'b0;
			ovf_q        <= 1'b0;
		end else begin
			line_start_q <= line_start_d;
			header_q     <= header_d;
			info_done_q  <= info_done_d;
			ac_seen_q    <= ac_seen_d;
			an_seen_q    <= an_seen_d;
			tab_q        <= tab_d;
			kmp_q        <= kmp_d;
			nt_q         <= nt_d;
			ac_q         <= ac_d;
			an_q         <= an_d;
			ac_found_q   <= ac_found_d;
			an_found_q   <= an_found_d;
			ovf_q        <= ovf_d;
		end
	end

	assign push = accept && is_lf;

	always_comb begin
		push_rec.is_header = header_q;
		push_rec.ac        = ac_q;
		push_rec.an        = an_q;
		if (header_q) begin
			push_rec.err = ERR_NONE;
		end else if (tab_q != INFO_TABS) begin
			push_rec.err = ERR_NO_INFO;
		end else if (!ac_found_q) begin
			push_rec.err = ERR_AC_MISSING;
		end else if (!an_found_q) begin
			push_rec.err = ERR_AN_MISSING;
		end else if (ovf_q) begin
			push_rec.err = ERR_OVERFLOW;
		end else begin
			push_rec.err = ERR_NONE;
		end
	end

endmodule
`default_nettype wire

@@ design/vcflf_queue.sv @@
// Short queue of classified line records between the parser and the verdict unit.
`default_nettype none
module vcflf_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  vcflf_pkg::line_rec_t  push_rec,
	input  logic                  pop,
	output vcflf_pkg::line_rec_t  head_rec,
	output logic                  not_empty,
	output logic                  full
);
	import vcflf_pkg::*;

	line_rec_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q;
	logic [QPTR_BITS-1:0]   rd_ptr_q;
	logic [QPTR_BITS:0]     count_q;

	assign full      = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_rec  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ design/vcflf_back.sv @@
// Verdict unit: threshold products in one stage, window compare into the output register.
`default_nettype none
module vcflf_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rec_valid,
	input  vcflf_pkg::line_rec_t          rec,
	output logic                          pop,
	input  logic                          cfg_we,
	input  logic [vcflf_pkg::BP_BITS-1:0] cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          is_header,
	output logic                          keep,
	output vcflf_pkg::count_t             allele_count,
	output vcflf_pkg::count_t             allele_number,
	output logic [2:0]                    error_code
);
	import vcflf_pkg::*;

	logic [BP_BITS-1:0]    t_q;
	logic [SCALE_BITS-1:0] hi_q;

	logic                  valid_s1;
	line_rec_t             rec_s1;
	logic [PROD_BITS-1:0]  low_s1;
	logic [PROD_BITS-1:0]  mid_s1;
	logic [PROD_BITS-1:0]  high_s1;

	logic                  valid_s2;
	logic                  load_s1;
	logic                  load_s2;

	assign load_s2 = !valid_s2 || out_ready;
	assign load_s1 = !valid_s1 || load_s2;
	assign pop     = rec_valid && load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q      <= BP_BITS'(BP_RESET);
			hi_q     <= SCALE_BITS'(BP_SCALE - BP_RESET);
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_we) begin
				t_q  <= cfg_data;
				hi_q <= SCALE_BITS'(BP_SCALE) - SCALE_BITS'(cfg_data);
			end
			if (load_s1) begin
				valid_s1 <= rec_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			rec_s1  <= rec;
			low_s1  <= PROD_BITS'(rec.an) * PROD_BITS'(t_q);
			mid_s1  <= PROD_BITS'(rec.ac) * PROD_BITS'(BP_SCALE);
			high_s1 <= PROD_BITS'(rec.an) * PROD_BITS'(hi_q);
		end
		if (load_s2) begin
			is_header     <= rec_s1.is_header;
			keep          <= rec_s1.is_header || ((rec_s1.err == ERR_NONE) &&
			                 (low_s1 <= mid_s1) && (mid_s1 <= high_s1));
			allele_count  <= rec_s1.ac;
			allele_number <= rec_s1.an;
			error_code    <= rec_s1.err;
		end
	end

	assign out_valid = valid_s2;

endmodule
`default_nettype wire

@@ design/vcf_common_variant_line_filter_core.sv @@
// Top level of the VCF common-variant line filter: parser, line queue and verdict unit.
//
//  Channel   Direction  Handshake              Payload
//  in        sink       in_valid / in_ready    data_byte
//  out       source     out_valid / out_ready  is_header, keep, allele_count,
//                                              allele_number, error_code
//  cfg       sink       cfg_valid / cfg_ready  min_maf_bp
//
// One byte is taken every cycle while the line queue is not full; the parser updates
// its line state in that cycle. Verdicts go through a product and an output register.
// Bytes stall only while the four-entry line queue is full of undelivered verdicts.
// Reset clears the line state and loads the default threshold; no clearing pass.
// The configuration port is always ready.
`default_nettype none
module vcf_common_variant_line_filter_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    data_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          is_header,
	output logic                          keep,
	output vcflf_pkg::count_t             allele_count,
	output vcflf_pkg::count_t             allele_number,
	output logic [2:0]                    error_code,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [vcflf_pkg::BP_BITS-1:0] min_maf_bp
);
	import vcflf_pkg::*;

	logic      accept;
	logic      push;
	line_rec_t push_rec;
	logic      pop;
	line_rec_t head_rec;
	logic      not_empty;
	logic      full;

	assign in_ready  = !full;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	vcflf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.data_byte(data_byte),
		.accept   (accept),
		.push     (push),
		.push_rec (push_rec)
	);

	vcflf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head_rec (head_rec),
		.not_empty(not_empty),
		.full     (full)
	);

	vcflf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rec_valid    (not_empty),
		.rec          (head_rec),
		.pop          (pop),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (min_maf_bp),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_header    (is_header),
		.keep         (keep),
		.allele_count (allele_count),
		.allele_number(allele_number),
		.error_code   (error_code)
	);

	a_header_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_header |-> keep && (error_code == ERR_NONE) &&
		(allele_count == '0) && (allele_number == '0))
		else $error("header verdict carries counts or an error");

	a_keep_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && keep && !is_header |-> (error_code == ERR_NONE))
		else $error("variant kept despite an error");

	a_overflow_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code == ERR_OVERFLOW) |->
		(allele_count == '1) || (allele_number == '1))
		else $error("overflow reported without a saturated count");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(is_header) && $stable(keep) &&
		$stable(allele_count) && $stable(allele_number) && $stable(error_code))
		else $error("waiting output transfer changed");

endmodule
`default_nettype wire
